// File: sv/owtcd_pkg.sv
// Shared types, codes and CRC helper for the 1-Wire ID table change detector.
`default_nettype none

package owtcd_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int GROUPS_DEF = 4;

    localparam int FUNC_W  = 2;
    localparam int GROUP_W = 2;
    localparam int SLOT_W  = 4;
    localparam int ID_W    = 64;
    localparam int KIND_W  = 2;
    localparam int MASK_W  = 16;

    localparam int CRC_BYTES = 7;

    localparam logic [7:0] FAMILY_CODE = 8'h28;
    localparam logic [7:0] CRC_POLY    = 8'h8C;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STORE   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [GROUP_W-1:0] group;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    rom_id;
    } t_in_word;

    typedef struct packed {
        logic               crc_error;
        logic [KIND_W-1:0]  change_kind;
        logic [SLOT_W-1:0]  change_slot;
        logic [MASK_W-1:0]  online_mask;
    } t_out_word;

    // one byte through the reflected CRC-8, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/owtcd_crc.sv
// Byte-serial CRC-8 unit over the first seven bytes of a ROM ID.
`default_nettype none

module owtcd_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [55:0] i_data,
    output logic        o_done,
    output logic [7:0]  o_crc
);
    import owtcd_pkg::*;

    localparam int CNT_W = $clog2(CRC_BYTES + 1);

    logic [55:0]      r_sh;
    logic [7:0]       r_crc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(CRC_BYTES);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: one byte per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_data;
            r_crc <= '0;
        end else if (r_run) begin
            r_crc <= crc8_byte(r_crc ^ r_sh[7:0]);
            r_sh  <= r_sh >> 8;
        end
    end

    assign o_done = r_done;
    assign o_crc  = r_crc;

endmodule

`default_nettype wire

// File: sv/onewire_id_table_change_detect_core.sv
// Top level: registered/scanned 1-Wire ID tables with CRC check and change detection.
// Steps from accept to result strobe: store/remove go straight to write-back; load
// runs the byte-serial CRC at one byte a cycle; compare copies the tables out of the
// ID memories at one entry a cycle, drains the read pipe, then compares one scan/table
// slot a cycle (a compare on an out-of-range group goes straight to write-back).
// Throughput: one item at a time; busy drops in the strobe cycle, so a new word can be
// taken there. Results cannot be stalled. Synchronous active-low reset clears online
// and scan-valid flags; the ID memories need no clearing pass.
`default_nettype none

module onewire_id_table_change_detect_core #(
    parameter int SLOTS  = owtcd_pkg::SLOTS_DEF,
    parameter int GROUPS = owtcd_pkg::GROUPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  owtcd_pkg::t_in_word  i_word,
    output logic                 o_valid,
    output owtcd_pkg::t_out_word o_result
);
    import owtcd_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int RD = GROUPS * SLOTS;
    localparam int AW = (RD > 1) ? $clog2(RD) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CRC  = 5'b00010,
        S_FILL = 5'b00100,
        S_CMP  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    // ID storage: registered IDs (group-major) and the scan table
    logic [ID_W-1:0] m_reg  [RD];
    logic [ID_W-1:0] m_scan [SLOTS];
    logic [ID_W-1:0] r_reg_rd;
    logic [ID_W-1:0] r_scan_rd;

    // working copies used while a compare runs
    logic [ID_W-1:0] r_tab_bank  [SLOTS];
    logic [ID_W-1:0] r_scan_bank [SLOTS];

    // online bit doubles as the "registered entry holds a family 0x28 ID" flag
    logic [SLOTS-1:0] r_online [GROUPS];
    logic [SLOTS-1:0] r_scan_vld;

    t_state          r_state, n_state;
    t_in_word        r_in;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_fill_v;
    logic [SW-1:0]   r_fill_idx;
    logic            r_add_f, n_add_f;
    logic [SW-1:0]   r_add_slot, n_add_slot;
    logic            r_rem_f, n_rem_f;
    logic [SW-1:0]   r_rem_slot, n_rem_slot;
    logic            r_valid;
    t_out_word       r_result, n_result;

    logic            w_accept;
    logic            w_in_group_ok;
    logic [GW-1:0]   w_gidx;
    logic [SW-1:0]   w_sidx;
    logic            w_group_ok;
    logic            w_slot_ok;
    logic            w_fam;
    logic            w_crc_err;
    logic            w_crc_done;
    logic [7:0]      w_crc;
    logic            w_rd_en;
    logic [SW-1:0]   w_rd_sidx;
    logic [AW-1:0]   w_rd_addr;
    logic [AW-1:0]   w_wr_addr;
    logic            w_scan_we;
    logic            w_reg_we;
    logic            w_online_we;
    logic            w_online_bit;
    logic [SLOTS-1:0] w_mask_new;
    logic [SLOTS-1:0] w_tab_vld;
    logic [SW-1:0]   w_ci;
    logic [ID_W-1:0] w_scan_cur;
    logic [ID_W-1:0] w_tab_cur;
    logic [SLOTS-1:0] w_eq_add;
    logic [SLOTS-1:0] w_eq_rem;
    logic            w_add_hit;
    logic            w_rem_hit;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_in_group_ok = 32'(i_word.group) < GROUPS;

    // decode of the word being worked on
    assign w_gidx     = GW'(r_in.group);
    assign w_sidx     = SW'(r_in.slot);
    assign w_group_ok = 32'(r_in.group) < GROUPS;
    assign w_slot_ok  = 32'(r_in.slot) < SLOTS;
    assign w_fam      = (r_in.rom_id[7:0] == FAMILY_CODE);
    assign w_crc_err  = w_fam && (w_crc != r_in.rom_id[63:56]);

    owtcd_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (i_word.func == FUNC_LOAD)),
        .i_data  (i_word.rom_id[55:0]),
        .o_done  (w_crc_done),
        .o_crc   (w_crc)
    );

    // ---------------------------------------------------------------
    // Memory ports: one read (copy-out during compare), one write (WB)
    // ---------------------------------------------------------------
    assign w_rd_en   = (r_state == S_FILL) && (r_cnt != CW'(SLOTS));
    assign w_rd_sidx = SW'(r_cnt);
    assign w_rd_addr = AW'(32'(w_gidx) * SLOTS + 32'(w_rd_sidx));
    assign w_wr_addr = AW'(32'(w_gidx) * SLOTS + 32'(w_sidx));

    assign w_scan_we = (r_state == S_WB) && (r_in.func == FUNC_LOAD) && w_slot_ok;
    assign w_reg_we  = (r_state == S_WB) && (r_in.func == FUNC_STORE) && w_group_ok
                       && w_slot_ok && w_fam;

    // Scan entries and registered entries are written with the raw ID; the valid
    // flags decide whether an entry takes part in any match.
    always_ff @(posedge i_clk) begin
        if (w_scan_we) begin
            m_scan[w_sidx] <= r_in.rom_id;
        end
        if (w_rd_en) begin
            r_scan_rd <= m_scan[w_rd_sidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_reg_we) begin
            m_reg[w_wr_addr] <= r_in.rom_id;
        end
        if (w_rd_en) begin
            r_reg_rd <= m_reg[w_rd_addr];
        end
    end

    // read data lands in the cycle after the address
    always_ff @(posedge i_clk) begin
        if (r_fill_v) begin
            r_tab_bank[r_fill_idx]  <= r_reg_rd;
            r_scan_bank[r_fill_idx] <= r_scan_rd;
        end
    end

    // ---------------------------------------------------------------
    // Compare step: slot w_ci checked both ways against the other table
    // ---------------------------------------------------------------
    assign w_tab_vld  = r_online[w_gidx];
    assign w_ci       = SW'(r_cnt);
    assign w_scan_cur = r_scan_bank[w_ci];
    assign w_tab_cur  = r_tab_bank[w_ci];

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            w_eq_add[j] = w_tab_vld[j] && (r_tab_bank[j] == w_scan_cur);
            w_eq_rem[j] = r_scan_vld[j] && (r_scan_bank[j] == w_tab_cur);
        end
    end

    assign w_add_hit = r_scan_vld[w_ci] && !(|w_eq_add);
    assign w_rem_hit = w_tab_vld[w_ci] && !(|w_eq_rem);

    // ---------------------------------------------------------------
    // Online bits after a store or remove
    // ---------------------------------------------------------------
    assign w_online_we  = (r_state == S_WB) && (r_in.func == FUNC_STORE || r_in.func == FUNC_REMOVE)
                          && w_group_ok && w_slot_ok;
    assign w_online_bit = (r_in.func == FUNC_STORE) && w_fam;

    always_comb begin
        w_mask_new = w_tab_vld;
        if (w_online_we) begin
            w_mask_new[w_sidx] = w_online_bit;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_add_f    = r_add_f;
        n_add_slot = r_add_slot;
        n_rem_f    = r_rem_f;
        n_rem_slot = r_rem_slot;
        n_result   = r_result;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt   = '0;
                    n_add_f = 1'b0;
                    n_rem_f = 1'b0;
                    if (i_word.func == FUNC_LOAD) begin
                        n_state = S_CRC;
                    end else if (i_word.func == FUNC_COMPARE && w_in_group_ok) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_WB;
                    end
                end
            end
            S_CRC: begin
                if (w_crc_done) begin
                    n_state = S_WB;
                end
            end
            S_FILL: begin
                if (r_cnt == CW'(SLOTS)) begin
                    n_cnt   = '0;
                    n_state = S_CMP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CMP: begin
                if (w_add_hit && !r_add_f) begin
                    n_add_f    = 1'b1;
                    n_add_slot = w_ci;
                end
                if (w_rem_hit && !r_rem_f) begin
                    n_rem_f    = 1'b1;
                    n_rem_slot = w_ci;
                end
                if (r_cnt == CW'(SLOTS - 1)) begin
                    n_state = S_WB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WB: begin
                n_state              = S_IDLE;
                n_result.crc_error   = (r_in.func == FUNC_LOAD) && w_slot_ok && w_crc_err;
                n_result.online_mask = w_group_ok ? MASK_W'(w_mask_new) : '0;
                if (r_add_f) begin
                    n_result.change_kind = KIND_ADDED;
                    n_result.change_slot = SLOT_W'(r_add_slot);
                end else if (r_rem_f) begin
                    n_result.change_kind = KIND_REMOVED;
                    n_result.change_slot = SLOT_W'(r_rem_slot);
                end else begin
                    n_result.change_kind = KIND_NONE;
                    n_result.change_slot = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_fill_v   <= 1'b0;
            r_add_f    <= 1'b0;
            r_rem_f    <= 1'b0;
            r_valid    <= 1'b0;
            r_scan_vld <= '0;
            for (int g = 0; g < GROUPS; g++) begin
                r_online[g] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_fill_v <= w_rd_en;
            r_add_f  <= n_add_f;
            r_rem_f  <= n_rem_f;
            r_valid  <= (r_state == S_WB);
            if (w_scan_we) begin
                r_scan_vld[w_sidx] <= w_fam && !w_crc_err;
            end
            if (w_online_we) begin
                r_online[w_gidx] <= w_mask_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_word;
        end
        r_fill_idx <= w_rd_sidx;
        r_add_slot <= n_add_slot;
        r_rem_slot <= n_rem_slot;
        r_result   <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: sv/owtcd_chk.sv
// Port-level checker for the ID table change detector, bound to the top level.
`default_nettype none

module owtcd_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input owtcd_pkg::t_in_word  i_word,
    input logic                 o_valid,
    input owtcd_pkg::t_out_word o_result
);
    import owtcd_pkg::*;

    // an accepted word makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a result only closes out work that was in flight
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) && !busy)
        else $error("result strobe without a word in flight");

    // one result per word: the strobe is never held
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // change kind is one of the three codes and never paired with a CRC error
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.change_kind == KIND_NONE
                     || o_result.change_kind == KIND_ADDED
                     || o_result.change_kind == KIND_REMOVED)
                    && !(o_result.crc_error && o_result.change_kind != KIND_NONE))
        else $error("illegal result kind");

    // no change means slot reads as zero
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.change_kind == KIND_NONE |-> o_result.change_slot == '0)
        else $error("change slot set without a change");

endmodule

bind onewire_id_table_change_detect_core owtcd_chk u_owtcd_chk (.*);

`default_nettype wire

// File: sim/owtcd_change_checker.sv
// Result checker for the 1-Wire ID table change detector: tracks the tables, predicts and compares.
module owtcd_change_checker import owtcd_pkg::*; #(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int GROUPS = GROUPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_word  i_word,
    input  logic      i_valid,
    input  t_out_word i_result,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ID_W-1:0]   scan_ids    [SLOTS];
    logic [ID_W-1:0]   reg_ids     [GROUPS][SLOTS];
    logic [MASK_W-1:0] online_bits [GROUPS];

    t_out_word expected_reports [$];
    int        fails   = 0;
    int        waiting = 0;

    assign o_errors  = fails;
    assign o_pending = waiting;

    function automatic logic is_family(input logic [ID_W-1:0] id);
        return id[7:0] == FAMILY_CODE;
    endfunction

    // reflected CRC-8 over bytes 0..6, LSB first
    function automatic logic [7:0] rom_crc8(input logic [ID_W-1:0] id);
        logic [7:0] crc;
        crc = '0;
        for (int b = 0; b < 7; b++) begin
            crc ^= id[8*b +: 8];
            for (int k = 0; k < 8; k++)
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    function automatic logic in_scan(input logic [ID_W-1:0] id);
        for (int j = 0; j < SLOTS; j++)
            if (is_family(scan_ids[j]) && scan_ids[j] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic in_group(input int g, input logic [ID_W-1:0] id);
        for (int j = 0; j < SLOTS; j++)
            if (is_family(reg_ids[g][j]) && reg_ids[g][j] == id) return 1'b1;
        return 1'b0;
    endfunction

    // applies one command word to the tracked tables, returns the report it yields
    function automatic t_out_word apply_word(input t_in_word w);
        t_out_word       r;
        logic [ID_W-1:0] id;
        int              g;
        int              s;
        logic            found;
        r     = '0;
        id    = w.rom_id;
        g     = w.group;
        s     = w.slot;
        found = 1'b0;
        case (w.func)
            FUNC_LOAD: begin
                if (s < SLOTS) begin
                    if (is_family(id) && rom_crc8(id) != id[63:56]) begin
                        scan_ids[s] = '0;
                        r.crc_error = 1'b1;
                    end else begin
                        scan_ids[s] = id;
                    end
                end
            end
            FUNC_COMPARE: begin
                if (g < GROUPS) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && is_family(scan_ids[i]) && !in_group(g, scan_ids[i])) begin
                            found         = 1'b1;
                            r.change_kind = KIND_ADDED;
                            r.change_slot = SLOT_W'(i);
                        end
                    end
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && is_family(reg_ids[g][i]) && !in_scan(reg_ids[g][i])) begin
                            found         = 1'b1;
                            r.change_kind = KIND_REMOVED;
                            r.change_slot = SLOT_W'(i);
                        end
                    end
                end
            end
            default: begin
                if (g < GROUPS && s < SLOTS) begin
                    if (w.func == FUNC_STORE && is_family(id)) begin
                        reg_ids[g][s]     = id;
                        online_bits[g][s] = 1'b1;
                    end else begin
                        reg_ids[g][s]     = '0;
                        online_bits[g][s] = 1'b0;
                    end
                end
            end
        endcase
        r.online_mask = (g < GROUPS) ? online_bits[g] : '0;
        return r;
    endfunction

    // results are retired before the word taken on the same edge is predicted
    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            foreach (scan_ids[s]) scan_ids[s] = '0;
            foreach (reg_ids[g, s]) reg_ids[g][s] = '0;
            foreach (online_bits[g]) online_bits[g] = '0;
            expected_reports.delete();
        end else begin
            if (i_valid) begin
                if (expected_reports.size() == 0) begin
                    $error("result word %h with no report expected", i_result);
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_result.crc_error !== want.crc_error) begin
                        $error("crc_error: expected %0d, got %0d",
                               want.crc_error, i_result.crc_error);
                        fails++;
                    end
                    if (i_result.change_kind !== want.change_kind) begin
                        $error("change_kind: expected %0d, got %0d",
                               want.change_kind, i_result.change_kind);
                        fails++;
                    end
                    if (i_result.change_slot !== want.change_slot) begin
                        $error("change_slot: expected %0d, got %0d",
                               want.change_slot, i_result.change_slot);
                        fails++;
                    end
                    if (i_result.online_mask !== want.online_mask) begin
                        $error("online_mask: expected %h, got %h",
                               want.online_mask, i_result.online_mask);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) expected_reports.push_back(apply_word(i_word));
        end
        waiting = expected_reports.size();
    end

endmodule

// File: sim/onewire_id_table_change_detect_core_tb.sv
// Drives directed and random load/compare/store/remove words into the change detector core.
module onewire_id_table_change_detect_core_tb import owtcd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_word  i_word  = '0;
    logic      o_valid;
    t_out_word o_result;
    int        errors;
    int        pending;

    // stimulus-side bookkeeping only: a pool of IDs with good CRC and what the
    // scan table should hold, so that table syncs can be built
    logic [ID_W-1:0] id_pool     [8];
    logic [ID_W-1:0] scan_shadow [16];
    int              sent     = 0;
    logic            burst    = 1'b0;
    int              mode_at  = 0;
    int              drain_at = 150;

    always #10 i_clk = ~i_clk;

    onewire_id_table_change_detect_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    owtcd_change_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_word    (i_word),
        .i_valid   (o_valid),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // family 0x28 in byte 0, 48-bit serial, CRC byte on top
    function automatic logic [ID_W-1:0] seal_id(input logic [47:0] serial);
        logic [ID_W-1:0] id;
        id         = {8'h00, serial, FAMILY_CODE};
        id[63:56]  = u_check.rom_crc8(id);
        return id;
    endfunction

    // mostly pooled good IDs so that compares find matches; the rest are
    // single-bit corruptions (CRC fail), raw noise and family-tagged noise
    function automatic logic [ID_W-1:0] pick_id();
        int          roll;
        logic [31:0] hi;
        roll = $urandom_range(0, 99);
        hi   = $urandom;
        if (roll < 70) return id_pool[$urandom_range(0, 7)];
        if (roll < 85) return id_pool[$urandom_range(0, 7)] ^ (64'h1 << $urandom_range(8, 63));
        if (roll < 93) return {$urandom, $urandom};
        return {hi, $urandom} & ~64'hFF | {56'h0, FAMILY_CODE};
    endfunction

    // Inputs move at the falling edge; the word is taken at the first rising
    // edge with busy low. start is left high on return so back-to-back words
    // never lower and raise it in the same step.
    task automatic send_word(input logic [FUNC_W-1:0] func, input int grp, input int slt,
                             input logic [ID_W-1:0] id);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_word.func   = func;
        i_word.group  = grp[GROUP_W-1:0];
        i_word.slot   = slt[SLOT_W-1:0];
        i_word.rom_id = id;
        start         = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (func == FUNC_LOAD)
            scan_shadow[slt[3:0]] = (id[7:0] == FAMILY_CODE &&
                                     u_check.rom_crc8(id) != id[63:56]) ? '0 : id;
        sent++;
    endtask

    // hold off until every report has come back
    task automatic drain();
        start = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // Copy the scan table into a group, so the next compare should see no
    // change; then sometimes knock one entry out and compare again.
    task automatic sync_group(input int grp);
        for (int s = 0; s < 16; s++) send_word(FUNC_STORE, grp, s, scan_shadow[s]);
        send_word(FUNC_COMPARE, grp, $urandom_range(0, 15), {$urandom, $urandom});
        if ($urandom_range(0, 1) == 1) begin
            send_word(FUNC_REMOVE, grp, $urandom_range(0, 15), {$urandom, $urandom});
            send_word(FUNC_COMPARE, grp, $urandom_range(0, 15), {$urandom, $urandom});
        end
    endtask

    initial begin : stimulus
        logic [47:0] serial;
        int          roll;

        // serial all zero and all ones in the first two pool entries
        id_pool[0] = seal_id(48'h0);
        id_pool[1] = seal_id('1);
        for (int i = 2; i < 8; i++) begin
            serial     = 48'({$urandom, $urandom});
            id_pool[i] = seal_id(serial);
        end
        foreach (scan_shadow[s]) scan_shadow[s] = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part ----
        send_word(FUNC_COMPARE, 0, 0, '0);                      // empty tables: no change
        send_word(FUNC_LOAD, 0, 0, id_pool[2]);                 // good CRC
        send_word(FUNC_LOAD, 0, 15, id_pool[3] ^ {8'h01, 56'h0}); // CRC byte wrong
        send_word(FUNC_LOAD, 0, 7, '1);                         // foreign family kept
        send_word(FUNC_LOAD, 3, 3, id_pool[0]);                 // zero serial
        send_word(FUNC_COMPARE, 0, 0, '0);                      // added, first scan slot
        send_word(FUNC_STORE, 0, 15, id_pool[2]);
        send_word(FUNC_STORE, 0, 14, id_pool[0]);
        send_word(FUNC_COMPARE, 0, 0, '0);                      // tables agree
        send_word(FUNC_STORE, 0, 0, id_pool[1]);
        send_word(FUNC_COMPARE, 0, 15, '1);                     // removed, table slot 0
        send_word(FUNC_STORE, 3, 15, '1);                       // foreign family clears
        send_word(FUNC_STORE, 3, 0, id_pool[4] ^ {8'hFF, 56'h0}); // store skips CRC check
        send_word(FUNC_COMPARE, 3, 0, '0);
        send_word(FUNC_REMOVE, 0, 0, '1);
        send_word(FUNC_COMPARE, 0, 0, '0);
        send_word(FUNC_LOAD, 0, 0, '0);                         // scan slot emptied
        send_word(FUNC_COMPARE, 0, 0, '0);                      // registered ID gone
        send_word(FUNC_REMOVE, 0, 15, '0);
        send_word(FUNC_REMOVE, 3, 0, '0);
        send_word(FUNC_LOAD, 2, 15, {56'hFF_FFFF_FFFF_FFFF, FAMILY_CODE});
        send_word(FUNC_STORE, 1, 5, id_pool[5]);
        send_word(FUNC_COMPARE, 2, 0, '0);
        send_word(FUNC_COMPARE, 1, 0, '0);

        // ---- random part ----
        mode_at = sent;
        while (sent < 1200) begin
            // some stretches run back to back, the rest with random gaps
            if (sent >= mode_at) begin
                burst   = ($urandom_range(0, 3) == 0);
                mode_at = sent + 64;
            end
            if (sent >= drain_at) begin
                drain();
                drain_at = sent + 300;
            end
            roll = $urandom_range(0, 99);
            if (roll < 40)
                send_word(FUNC_LOAD, $urandom_range(0, 3), $urandom_range(0, 15), pick_id());
            else if (roll < 62)
                send_word(FUNC_COMPARE, $urandom_range(0, 3), $urandom_range(0, 15),
                          {$urandom, $urandom});
            else if (roll < 78)
                send_word(FUNC_STORE, $urandom_range(0, 3), $urandom_range(0, 15), pick_id());
            else if (roll < 88)
                send_word(FUNC_REMOVE, $urandom_range(0, 3), $urandom_range(0, 15),
                          {$urandom, $urandom});
            else if (roll < 92)
                sync_group($urandom_range(0, 3));
            else
                send_word(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 3),
                          $urandom_range(0, 15), {$urandom, $urandom});
        end

        // let the last reports arrive, then watch for strays past the longest latency
        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
